/* rtl/tsg_pkg.sv */
// Shared types and constants of the text-mode scanline generator.
// Used by the channel interfaces and every module of the block; depends on nothing.
package tsg_pkg;

  // Screen and timing geometry
  localparam int COLUMNS      = 32;
  localparam int ROWS         = 24;
  localparam int GLYPH_HEIGHT = 8;
  localparam int TOTAL_LINES  = 262;
  localparam int FIRST_ACTIVE = 47;
  localparam int SYNC_LINES   = 3;
  localparam int ACTIVE_LINES = ROWS * GLYPH_HEIGHT;
  localparam int SCREEN_CELLS = COLUMNS * ROWS;
  localparam int FONT_BYTES   = 256 * GLYPH_HEIGHT;

  // Field widths
  localparam int FUNC_W  = 2;
  localparam int ADDR_W  = 11;
  localparam int DATA_W  = 8;
  localparam int LINE_W  = 9;
  localparam int COL_W   = 5;
  localparam int PIX_W   = 8;
  localparam int CUR_W   = 6;
  localparam int MASK_W  = 8;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int SUB_W   = $clog2(GLYPH_HEIGHT);
  localparam int SCR_AW  = $clog2(SCREEN_CELLS);
  localparam int FONT_AW = $clog2(FONT_BYTES);

  localparam logic [DATA_W-1:0] FILL_GLYPH = 8'h8f;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK      = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_SCREEN = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WR_FONT   = 2'd2;

  // Configuration port
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_CURSOR_COL  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CURSOR_ROW  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INVERT_MASK = 2'd2;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_WR_SCREEN,
    CMD_WR_FONT,
    CMD_BLANK,
    CMD_ACTIVE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
    logic [LINE_W-1:0]  line;
    logic [ROW_W-1:0]   row;
    logic [SUB_W-1:0]   sub;
  } cmd_t;

  typedef struct packed {
    logic [CUR_W-1:0]  cursor_col;
    logic [CUR_W-1:0]  cursor_row;
    logic [MASK_W-1:0] invert_mask;
  } cfg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FILL,
    BK_FILLW,
    BK_RUN
  } bk_state_t;

endpackage

/* rtl/tsg_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on tsg_pkg for the field widths.
interface tsg_in_if import tsg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;

  modport source (output valid, func, addr, data, input ready);
  modport sink   (input valid, func, addr, data, output ready);
endinterface

interface tsg_out_if import tsg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] line;
  logic              long_sync;
  logic              active;
  logic [COL_W-1:0]  column;
  logic [PIX_W-1:0]  pixels;
  logic              last;

  modport source (output valid, line, long_sync, active, column, pixels, last, input ready);
  modport sink   (input valid, line, long_sync, active, column, pixels, last, output ready);
endinterface

/* rtl/tsg_front.sv */
// Front end: accepts input transactions, keeps the scanline counter and
// classifies each item into a back-end command. Depends on tsg_pkg, tsg_in_if.
module tsg_front import tsg_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  tsg_in_if.sink in_ch,
  input  logic   q_full,
  output logic   push,
  output cmd_t   push_cmd
);

  logic [LINE_W-1:0] line_r;
  logic [LINE_W-1:0] line_inc;
  logic [LINE_W-1:0] line_nxt;
  logic [LINE_W-1:0] rel;
  logic              in_active;
  logic              accept;
  logic              keep;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    line_inc  = line_r + 1'b1;
    line_nxt  = (line_inc >= LINE_W'(TOTAL_LINES)) ? '0 : line_inc;
    rel       = line_nxt - LINE_W'(FIRST_ACTIVE);
    in_active = (line_nxt >= LINE_W'(FIRST_ACTIVE)) && (rel < LINE_W'(ACTIVE_LINES));

    push_cmd      = '0;
    push_cmd.addr = in_ch.addr;
    push_cmd.data = in_ch.data;
    push_cmd.line = line_nxt;
    push_cmd.row  = rel[SUB_W +: ROW_W];
    push_cmd.sub  = rel[SUB_W-1:0];
    keep          = 1'b0;
    unique case (in_ch.func)
      FUNC_TICK: begin
        push_cmd.kind = in_active ? CMD_ACTIVE : CMD_BLANK;
        keep          = 1'b1;
      end
      FUNC_WR_SCREEN: begin
        push_cmd.kind = CMD_WR_SCREEN;
        keep          = (int'(in_ch.addr) < SCREEN_CELLS);
      end
      FUNC_WR_FONT: begin
        push_cmd.kind = CMD_WR_FONT;
        keep          = (int'(in_ch.addr) < FONT_BYTES);
      end
      default: begin
        // unused function code: take and drop
        push_cmd.kind = CMD_BLANK;
        keep          = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
    end else if (accept && in_ch.func == FUNC_TICK) begin
      line_r <= line_nxt;
    end
  end

endmodule

/* rtl/tsg_cmd_queue.sv */
// Short command queue that decouples the front end from the back end.
// Depends on tsg_pkg.
module tsg_cmd_queue import tsg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/tsg_back.sv */
// Back end: owns screen and font memories, runs the per-line read pipeline
// and holds the result register. Depends on tsg_pkg and tsg_out_if.
module tsg_back import tsg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  tsg_out_if.source  out_ch
);

  logic [DATA_W-1:0] screen_mem [SCREEN_CELLS];
  logic [DATA_W-1:0] font_mem   [FONT_BYTES];

  bk_state_t          state_r, state_nxt;
  logic [LINE_W-1:0]  line_r;
  logic [ROW_W-1:0]   row_r;
  logic [SUB_W-1:0]   sub_r;
  logic [PIX_W-1:0]   fill_r;
  logic [COL_W-1:0]   cnt_r;
  logic               issue_done_r;
  logic               v1_r, v2_r;
  logic [COL_W-1:0]   c1_r, c2_r;
  logic [DATA_W-1:0]  scr_q_r;
  logic [DATA_W-1:0]  font_q_r;

  logic               out_valid_r;
  logic [LINE_W-1:0]  out_line_r;
  logic               out_long_sync_r;
  logic               out_active_r;
  logic [COL_W-1:0]   out_column_r;
  logic [PIX_W-1:0]   out_pixels_r;
  logic               out_last_r;

  logic               adv;
  logic               issue;
  logic               start;
  logic               wr_scr, wr_font;
  logic               load_blank, load_pix;
  logic               fill_rd, font_en;
  logic [SCR_AW-1:0]  scr_addr;
  logic [FONT_AW-1:0] font_addr;
  logic               cursor_hit;
  logic [PIX_W-1:0]   pix;
  logic [LINE_W-1:0]  res_line;

  // Pipeline and result register move together whenever the result slot frees
  assign adv = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    start      = 1'b0;
    wr_scr     = 1'b0;
    wr_font    = 1'b0;
    load_blank = 1'b0;
    load_pix   = 1'b0;
    issue      = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.kind)
            CMD_WR_SCREEN: begin
              pop    = 1'b1;
              wr_scr = 1'b1;
            end
            CMD_WR_FONT: begin
              pop     = 1'b1;
              wr_font = 1'b1;
            end
            CMD_BLANK: begin
              pop        = adv;
              load_blank = adv;
            end
            CMD_ACTIVE: begin
              pop       = 1'b1;
              start     = 1'b1;
              state_nxt = BK_FILL;
            end
            default: ;
          endcase
        end
      end
      BK_FILL:  state_nxt = BK_FILLW;
      BK_FILLW: state_nxt = BK_RUN;
      BK_RUN: begin
        issue    = adv && !issue_done_r;
        load_pix = adv && v2_r;
        if (load_pix && c2_r == COL_W'(COLUMNS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    fill_rd    = (state_r == BK_FILL);
    font_en    = fill_rd || adv;
    scr_addr   = {row_r, cnt_r};
    font_addr  = fill_rd ? {FILL_GLYPH, sub_r} : {scr_q_r, sub_r};
    cursor_hit = (CUR_W'(row_r) == cfg.cursor_row) && (CUR_W'(c2_r) == cfg.cursor_col);
    pix        = font_q_r ^ (cursor_hit ? fill_r : '0) ^ cfg.invert_mask;
    res_line   = load_blank ? q_cmd.line : line_r;
  end

  // Memories: writes only happen while the read pipeline is empty
  always_ff @(posedge clk) begin
    if (wr_scr) begin
      screen_mem[q_cmd.addr[SCR_AW-1:0]] <= q_cmd.data;
    end
    if (wr_font) begin
      font_mem[q_cmd.addr[FONT_AW-1:0]] <= q_cmd.data;
    end
    if (adv) begin
      scr_q_r <= screen_mem[scr_addr];
    end
    if (font_en) begin
      font_q_r <= font_mem[font_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      issue_done_r <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        issue_done_r <= 1'b0;
      end else if (issue && cnt_r == COL_W'(COLUMNS - 1)) begin
        issue_done_r <= 1'b1;
      end
      if (adv) begin
        v1_r <= issue;
        v2_r <= v1_r;
      end
      if (load_blank || load_pix) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      line_r <= q_cmd.line;
      row_r  <= q_cmd.row;
      sub_r  <= q_cmd.sub;
      cnt_r  <= '0;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == BK_FILLW) begin
      fill_r <= font_q_r;
    end
    if (adv) begin
      c1_r <= cnt_r;
      c2_r <= c1_r;
    end
    if (load_blank || load_pix) begin
      out_line_r      <= res_line;
      out_long_sync_r <= (res_line < LINE_W'(SYNC_LINES));
      out_active_r    <= load_pix;
      out_column_r    <= load_pix ? c2_r : '0;
      out_pixels_r    <= load_pix ? pix : '0;
      out_last_r      <= load_blank || (c2_r == COL_W'(COLUMNS - 1));
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.line      = out_line_r;
  assign out_ch.long_sync = out_long_sync_r;
  assign out_ch.active    = out_active_r;
  assign out_ch.column    = out_column_r;
  assign out_ch.pixels    = out_pixels_r;
  assign out_ch.last      = out_last_r;

endmodule

/* rtl/text_mode_scanline_generator.sv */
// Top level of the text-mode scanline generator: configuration registers,
// front end, command queue and back end. Depends on tsg_pkg, tsg_if, tsg_front, tsg_cmd_queue and tsg_back.
//
// Usage:
//  - in_ch carries transactions: func 0 is a line tick, func 1 writes a screen
//    cell (addr = row*32+col), func 2 writes a font row (addr = code*8+row).
//    Writes and unused codes produce no result; out-of-range writes are dropped.
//  - out_ch returns one blank transaction per tick outside the active lines, or
//    32 pixel transactions (column 0 upward, last on column 31) on lines 47..238.
//  - cfg_* is an APB write/read port for cursor_col (0x0), cursor_row (0x4) and
//    invert_mask (0x8); write it only while the block is idle.
// Timing:
//  - An accepted item is written into the queue at the accepting clock edge;
//    the back end takes it when idle; a blank result loads when the slot frees.
//  - Writes are carried out from the queue head while the back end stays idle.
//    An active line takes the command, fetches the cursor fill row, feeds the
//    columns from 0 upward through the screen read / font read pipeline (one
//    read port per memory), and then drains the pipeline.
//  - Reset clears the scanline counter, queue, pipeline and cfg registers; the
//    memories are not cleared and must be written before they are shown.
//  - When the receiver stalls, the pipeline freezes behind the result register,
//    the four-entry queue fills, and then in_ch.ready drops.
module text_mode_scanline_generator import tsg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tsg_in_if.sink            in_ch,
  tsg_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t                 cfg_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  logic push, pop, q_full, q_valid;
  cmd_t push_cmd, q_cmd;

  // APB register file: never inserts wait states, write on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[2 +: REG_IDX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CURSOR_COL:  cfg_r.cursor_col  <= cfg_pwdata[CUR_W-1:0];
        REG_CURSOR_ROW:  cfg_r.cursor_row  <= cfg_pwdata[CUR_W-1:0];
        REG_INVERT_MASK: cfg_r.invert_mask <= cfg_pwdata[MASK_W-1:0];
        default: ;  // hole in the map: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CURSOR_COL:  cfg_prdata = CFG_DW'(cfg_r.cursor_col);
      REG_CURSOR_ROW:  cfg_prdata = CFG_DW'(cfg_r.cursor_row);
      REG_INVERT_MASK: cfg_prdata = CFG_DW'(cfg_r.invert_mask);
      default:         cfg_prdata = '0;
    endcase
  end

  // Classify items and advance the scanline counter
  tsg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Hold commands while the back end is busy or stalled
  tsg_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Execute writes and render lines
  tsg_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/tsg_checker.sv */
// Port-level checker for the text-mode scanline generator and its bind.
// Depends on tsg_pkg; sees only the top level's result channel.
module tsg_checker import tsg_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [LINE_W-1:0] out_line,
  input logic              out_long_sync,
  input logic              out_active,
  input logic [COL_W-1:0]  out_column,
  input logic [PIX_W-1:0]  out_pixels,
  input logic              out_last
);

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line) && $stable(out_pixels)
      && $stable(out_column) && $stable(out_last))
    else $error("result changed while stalled");

  // Pixel bytes of one line come out column by column
  a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_active && !out_last |=>
      !out_valid || (out_active && out_column == $past(out_column) + 1'b1
        && out_line == $past(out_line)))
    else $error("pixel column out of order");

  // Blank results are a single empty transaction
  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_active |-> out_last && out_column == '0 && out_pixels == '0)
    else $error("malformed blank result");

  // Sync flag and line range agree
  a_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line < LINE_W'(TOTAL_LINES)
      && out_long_sync == (out_line < LINE_W'(SYNC_LINES)))
    else $error("line number or sync flag wrong");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind text_mode_scanline_generator tsg_checker u_tsg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_line      (out_ch.line),
  .out_long_sync (out_ch.long_sync),
  .out_active    (out_ch.active),
  .out_column    (out_ch.column),
  .out_pixels    (out_ch.pixels),
  .out_last      (out_ch.last)
);

/* sim/tb_text_mode_scanline_generator.sv */
// Self-checking testbench for text_mode_scanline_generator: a line predictor class
// tracks the screen, font, cursor and line counter and checks every result transaction.
// Depends on rtl/tsg_pkg.sv, rtl/tsg_if.sv and the block's RTL.
import tsg_pkg::*;

typedef struct packed {
  logic [LINE_W-1:0] line;
  logic              long_sync;
  logic              active;
  logic [COL_W-1:0]  column;
  logic [PIX_W-1:0]  pixels;
  logic              last;
} beat_t;

// Predicts the result transactions of each accepted item and checks them in order.
class line_predictor;
  int unsigned line_no;
  logic [DATA_W-1:0] screen [SCREEN_CELLS];
  logic [DATA_W-1:0] font [FONT_BYTES];
  bit screen_set [SCREEN_CELLS];
  bit font_set [FONT_BYTES];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [MASK_W-1:0] mask;
  beat_t beats_due [$];
  int errors;

  function new();
    line_no = 0;
    cur_col = 0;
    cur_row = 0;
    mask    = '0;
    errors  = 0;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_CURSOR_COL:  cur_col = val[CUR_W-1:0];
      REG_CURSOR_ROW:  cur_row = val[CUR_W-1:0];
      REG_INVERT_MASK: mask    = val[MASK_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [CFG_DW-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_CURSOR_COL:  return CFG_DW'(cur_col);
      REG_CURSOR_ROW:  return CFG_DW'(cur_row);
      REG_INVERT_MASK: return CFG_DW'(mask);
      default:         return '0;
    endcase
  endfunction

  function int unsigned next_line();
    return (line_no + 1 >= TOTAL_LINES) ? 0 : line_no + 1;
  endfunction

  function bit is_active(int unsigned ln);
    return ln >= FIRST_ACTIVE && ln - FIRST_ACTIVE < ACTIVE_LINES;
  endfunction

  function void note_item(logic [FUNC_W-1:0] func, logic [ADDR_W-1:0] addr,
                          logic [DATA_W-1:0] data);
    int unsigned rel, row, sub, x;
    logic [PIX_W-1:0] fill, pix;
    beat_t b;
    case (func)
      FUNC_WR_SCREEN: begin
        if (addr < SCREEN_CELLS) begin
          screen[addr]     = data;
          screen_set[addr] = 1'b1;
        end
      end
      FUNC_WR_FONT: begin
        if (addr < FONT_BYTES) begin
          font[addr]     = data;
          font_set[addr] = 1'b1;
        end
      end
      FUNC_TICK: begin
        line_no     = next_line();
        b.line      = LINE_W'(line_no);
        b.long_sync = line_no < SYNC_LINES;
        if (is_active(line_no)) begin
          rel  = line_no - FIRST_ACTIVE;
          row  = rel / GLYPH_HEIGHT;
          sub  = rel % GLYPH_HEIGHT;
          fill = font[int'(FILL_GLYPH) * GLYPH_HEIGHT + sub];
          for (x = 0; x < COLUMNS; x++) begin
            pix = font[int'(screen[row * COLUMNS + x]) * GLYPH_HEIGHT + sub];
            if (x == cur_col && row == cur_row) pix ^= fill;
            b.active = 1'b1;
            b.column = COL_W'(x);
            b.pixels = pix ^ mask;
            b.last   = (x == COLUMNS - 1);
            beats_due.push_back(b);
          end
        end else begin
          b.active = 1'b0;
          b.column = '0;
          b.pixels = '0;
          b.last   = 1'b1;
          beats_due.push_back(b);
        end
      end
      default: ;  // unused code: drop
    endcase
  endfunction

  function void check_beat(beat_t got);
    beat_t want;
    if (beats_due.size() == 0) begin
      flag($sformatf("unexpected result: line %0d active %0b col %0d pix %02h last %0b",
                     got.line, got.active, got.column, got.pixels, got.last));
      return;
    end
    want = beats_due.pop_front();
    if (got.line !== want.line || got.long_sync !== want.long_sync ||
        got.active !== want.active || got.column !== want.column ||
        got.pixels !== want.pixels || got.last !== want.last)
      flag($sformatf({"mismatch: expected line %0d sync %0b active %0b col %0d pix %02h ",
                      "last %0b, got line %0d sync %0b active %0b col %0d pix %02h last %0b"},
                     want.line, want.long_sync, want.active, want.column, want.pixels,
                     want.last, got.line, got.long_sync, got.active, got.column,
                     got.pixels, got.last));
  endfunction
endclass

module tb_text_mode_scanline_generator;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int QUIET_LIMIT     = 2000;  // cycles with no transaction on either channel
  localparam int SETTLE_CYCLES   = 16;    // covers writes still queued behind the last result
  localparam int TICKS_PER_PHASE = 2;     // four phases cover the glyph rows of character row 0

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  tsg_in_if  in_if ();
  tsg_out_if out_if ();

  text_mode_scanline_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  line_predictor pred = new();

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int quiet_cycles  = 0;

  // Idle and stall percentages and cursor settings, one entry per random phase.
  // Phases 0 and 2 put the cursor on character row 0; phase 1 hides it by row,
  // phase 3 by column.
  int in_idle_tbl  [4] = '{0, 74, 0, 38};
  int out_stall_tbl[4] = '{0, 0, 74, 38};
  int col_tbl      [4] = '{3, 5, 31, 32};
  int row_tbl      [4] = '{0, 24, 0, 0};

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: decide ready at each falling edge from the current stall rate.
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Check each result transaction at the rising edge; count quiet cycles for the watchdog.
  always @(posedge clk) begin
    beat_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.line      = out_if.line;
        got.long_sync = out_if.long_sync;
        got.active    = out_if.active;
        got.column    = out_if.column;
        got.pixels    = out_if.pixels;
        got.last      = out_if.last;
        pred.check_beat(got);
      end
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_text_mode_scanline_generator failed");
          $finish;
        end
      end
    end
  end

  // Offer one item, idling first at the sender's rate; return at the falling edge
  // after the transaction so the next call can keep valid high.
  task automatic push_item(input logic [FUNC_W-1:0] func, input int unsigned addr,
                           input int unsigned data);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= func;
    in_if.addr  <= ADDR_W'(addr);
    in_if.data  <= DATA_W'(data);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pred.note_item(func, ADDR_W'(addr), DATA_W'(data));
    @(negedge clk);
  endtask

  // Hold the sender until every expected result is in, then let queued writes drain.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pred.beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write followed by a read back of the same register.
  task automatic set_register(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= CFG_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    pred.write_reg(idx, CFG_DW'(value));
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== pred.reg_value(idx))
      pred.flag($sformatf("register %0d read back %08h, expected %08h",
                          idx, cfg_prdata, pred.reg_value(idx)));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_cursor(input int unsigned col, input int unsigned row,
                            input int unsigned mask);
    set_register(REG_CURSOR_COL, col);
    set_register(REG_CURSOR_ROW, row);
    set_register(REG_INVERT_MASK, mask);
  endtask

  // Before a tick that lands on an active line, write every screen cell of that
  // character row and every font row it will show (fill glyph included) that was
  // never written, so no read ever hits unwritten memory. Keep the primed codes
  // to a few values so each line needs only a handful of font rows.
  task automatic prime_next_line();
    int unsigned ln, row, sub, idx, fa, x;
    ln = pred.next_line();
    if (!pred.is_active(ln)) return;
    row = (ln - FIRST_ACTIVE) / GLYPH_HEIGHT;
    sub = (ln - FIRST_ACTIVE) % GLYPH_HEIGHT;
    for (x = 0; x < COLUMNS; x++) begin
      idx = row * COLUMNS + x;
      if (!pred.screen_set[idx])
        push_item(FUNC_WR_SCREEN, idx,
                  ($urandom_range(7) == 0) ? int'(FILL_GLYPH) : $urandom_range(1));
    end
    for (x = 0; x <= COLUMNS; x++) begin
      fa = (x == COLUMNS) ? int'(FILL_GLYPH) * GLYPH_HEIGHT + sub
                          : int'(pred.screen[row * COLUMNS + x]) * GLYPH_HEIGHT + sub;
      if (!pred.font_set[fa]) push_item(FUNC_WR_FONT, fa, $urandom_range(255));
    end
  endtask

  initial begin
    int p, ticks, pick;
    int unsigned addr;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.func   = FUNC_TICK;
    in_if.addr   = '0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: register defaults, then field extremes, the unused code,
    // out-of-range screen writes, the first ticks through vertical sync and
    // the blank lines up to the one before the first active line.
    set_cursor(0, 0, 0);
    push_item(FUNC_UNUSED, 2047, 255);
    push_item(FUNC_WR_SCREEN, SCREEN_CELLS, 8'h55);
    push_item(FUNC_WR_SCREEN, 2047, 8'haa);
    push_item(FUNC_WR_SCREEN, 0, FILL_GLYPH);
    push_item(FUNC_WR_SCREEN, SCREEN_CELLS - 1, 255);
    push_item(FUNC_WR_SCREEN, COLUMNS - 1, 0);
    push_item(FUNC_WR_FONT, 0, 0);
    push_item(FUNC_WR_FONT, FONT_BYTES - 1, 255);
    push_item(FUNC_WR_FONT, int'(FILL_GLYPH) * GLYPH_HEIGHT, 8'h81);
    push_item(FUNC_TICK, 0, 0);
    push_item(FUNC_TICK, 2047, 255);
    push_item(FUNC_TICK, 1024, 8'h80);
    while (pred.next_line() != FIRST_ACTIVE)
      push_item(FUNC_TICK, $urandom_range(2047), $urandom_range(255));
    settle();

    // Random phases: each sets the cursor while idle, then runs ticks mixed with
    // writes and noise; together they walk the glyph rows of character row 0.
    for (p = 0; p < 4; p++) begin
      in_idle_pct   = in_idle_tbl[p];
      out_stall_pct = out_stall_tbl[p];
      case (p)
        0:       set_cursor(col_tbl[p], row_tbl[p], 8'ha5);
        1:       set_cursor(col_tbl[p], row_tbl[p], 8'hff);
        2:       set_cursor(col_tbl[p], row_tbl[p], $urandom_range(255));
        default: set_cursor(col_tbl[p], row_tbl[p], 8'h00);
      endcase
      ticks = 0;
      while (ticks < TICKS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          prime_next_line();
          push_item(FUNC_TICK, $urandom_range(2047), $urandom_range(255));
          ticks++;
        end else if (pick < 70) begin
          // mostly legal cells; now and then an address past the screen
          addr = ($urandom_range(9) == 0) ? $urandom_range(2047, SCREEN_CELLS)
                                          : $urandom_range(SCREEN_CELLS - 1);
          push_item(FUNC_WR_SCREEN, addr,
                    ($urandom_range(7) == 0) ? int'(FILL_GLYPH) : $urandom_range(255));
        end else if (pick < 95) begin
          push_item(FUNC_WR_FONT, $urandom_range(FONT_BYTES - 1), $urandom_range(255));
        end else begin
          push_item(FUNC_UNUSED, $urandom_range(2047), $urandom_range(255));
        end
      end
      settle();
    end

    if (pred.errors == 0 && pred.beats_due.size() == 0) begin
      $display("tb_text_mode_scanline_generator passed");
    end else begin
      $display("tb_text_mode_scanline_generator failed");
    end
    $finish;
  end

endmodule

/* text_mode_scanline_generator.f */
rtl/tsg_pkg.sv
rtl/tsg_if.sv
rtl/tsg_front.sv
rtl/tsg_cmd_queue.sv
rtl/tsg_back.sv
rtl/text_mode_scanline_generator.sv
rtl/tsg_checker.sv
sim/tb_text_mode_scanline_generator.sv
